FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TOSU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tosu checker: assertion failed");

// Next-cycle implication, disabled during reset.
`define TOSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tosu checker: assertion failed");

`endif

FILE: sv/tosu_pkg.sv
// Package: shared constants and types of the tracked object state update block.
`default_nettype none

package tosu_pkg;

    localparam int ACC_W     = 50;
    localparam int TIME_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int HEALTH_W  = 17;
    localparam int CFG_IDX_W = 3;
    localparam int ID_W      = 32;

    localparam logic [HEALTH_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [FRAC_W-1:0]   ROUND_Q16 = 16'h8000;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_MATCH = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH  = 3'd0,
        CFG_PENALTY = 3'd1,
        CFG_PERIOD  = 3'd2,
        CFG_DEATH   = 3'd3,
        CFG_PDEATH  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

FILE: sv/tosu_serial_unit.sv
// Shared serial unit: shift-add multiply-accumulate and restoring divide, one bit per cycle.
`default_nettype none

module tosu_serial_unit #(
    parameter int MPLR_W = 25,
    parameter int CNT_W  = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire tosu_pkg::t_unit_cmd       i_cmd,
    input  wire logic [CNT_W-1:0]          i_count,
    input  wire logic [tosu_pkg::ACC_W-1:0] i_acc_init,
    input  wire logic [tosu_pkg::ACC_W-1:0] i_a,
    input  wire logic [MPLR_W-1:0]         i_b,
    output tosu_pkg::t_unit_stat           o_stat,
    output logic [tosu_pkg::ACC_W-1:0]     o_acc,
    output logic [MPLR_W-1:0]              o_b
);

    logic [tosu_pkg::ACC_W-1:0] r_acc;
    logic [tosu_pkg::ACC_W-1:0] r_a;
    logic [MPLR_W-1:0]          r_b;
    tosu_pkg::t_op              r_op;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [tosu_pkg::ACC_W-1:0] w_sum;
    logic [tosu_pkg::ACC_W-1:0] w_shl;
    logic [tosu_pkg::ACC_W-1:0] w_sub;
    logic                       w_ge;

    always_comb begin
        w_sum = r_acc + (r_b[0] ? r_a : '0);
        w_shl = {r_acc[tosu_pkg::ACC_W-2:0], 1'b0};
        w_ge  = w_shl >= r_a;
        w_sub = w_shl - r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_acc <= i_acc_init;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            case (r_op)
                tosu_pkg::OP_MUL: begin
                    r_acc <= w_sum;
                    r_a   <= {r_a[tosu_pkg::ACC_W-2:0], 1'b0};
                    r_b   <= {1'b0, r_b[MPLR_W-1:1]};
                end
                tosu_pkg::OP_DIV: begin
                    r_acc <= w_ge ? w_sub : w_shl;
                    r_b   <= {r_b[MPLR_W-2:0], w_ge};
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_acc       = r_acc;
    assign o_b         = r_b;

endmodule

`default_nettype wire

FILE: sv/tracked_object_state_update.sv
// Top level: single-object track with alpha smoothing, provisional phase and health decay.
// One transaction is taken while o_ready is high and then runs through a sequencer over one
// shared serial unit that retires one bit per cycle: two squares over POS_WIDTH+1 bits, two
// blends with the 16-bit smoothing weight on matched updates, and up to two divisions with
// 16-bit quotients for provisionality and health. Each phase includes a launch and a handoff.
// The result sits in an output register, and the next transaction is taken while it waits;
// the block only holds in its final state until that register is free.
`default_nettype none

module tracked_object_state_update #(
    parameter int POS_WIDTH = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [1:0]                          i_mode,
    input  wire logic signed [POS_WIDTH-1:0]         i_meas_x,
    input  wire logic signed [POS_WIDTH-1:0]         i_meas_z,
    input  wire logic [tosu_pkg::TIME_W-1:0]         i_cur_time,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [tosu_pkg::ID_W-1:0]                o_track_id,
    output logic signed [POS_WIDTH-1:0]              o_pos_x,
    output logic signed [POS_WIDTH-1:0]              o_pos_z,
    output logic [tosu_pkg::ACC_W-1:0]               o_match_cost,
    output logic [tosu_pkg::HEALTH_W-1:0]            o_health,
    output logic [tosu_pkg::HEALTH_W-1:0]            o_provisionality,
    output logic [tosu_pkg::TIME_W-1:0]              o_age,
    output logic                                     o_is_provisional,
    output logic                                     o_is_matched,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [tosu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tosu_pkg::TIME_W-1:0]         i_cfg_data
);

    localparam int PW     = POS_WIDTH + 1;
    localparam int MPLR_W = (PW > tosu_pkg::FRAC_W) ? PW : tosu_pkg::FRAC_W;
    localparam int CNT_W  = $clog2(MPLR_W + 1);
    localparam int AW     = tosu_pkg::ACC_W;
    localparam int TW     = tosu_pkg::TIME_W;
    localparam int FW     = tosu_pkg::FRAC_W;
    localparam int HW     = tosu_pkg::HEALTH_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SQX  = 8'b0000_0010,
        S_SQZ  = 8'b0000_0100,
        S_BLX  = 8'b0000_1000,
        S_BLZ  = 8'b0001_0000,
        S_DVP  = 8'b0010_0000,
        S_DVH  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_go;

    // configuration
    logic [FW-1:0] r_smooth;
    logic [TW-1:0] r_penalty, r_period, r_death, r_pdeath;

    // track state
    logic                        r_live, r_flag;
    logic signed [POS_WIDTH-1:0] r_px, r_pz;
    logic [TW-1:0]               r_last, r_promote, r_est;
    logic [tosu_pkg::ID_W-1:0]   r_next_id, r_cur_id;

    // transaction and intermediates
    logic [1:0]                  r_mode;
    logic signed [POS_WIDTH-1:0] r_mx, r_mz;
    logic [TW-1:0]               r_now;
    logic [AW-1:0]               r_cost;
    logic signed [POS_WIDTH-1:0] r_new_x, r_new_z;
    logic [HW-1:0]               r_prov_q, r_health_q;

    // unit interface
    tosu_pkg::t_unit_cmd  w_cmd;
    tosu_pkg::t_unit_stat w_stat;
    logic [CNT_W-1:0]     w_count;
    logic [AW-1:0]        w_init, w_a, w_acc;
    logic [MPLR_W-1:0]    w_b, w_bout;

    logic                        w_start, w_live, w_matched, w_update;
    logic [TW-1:0]               w_promote_mid, w_last_mid, w_est_mid, w_est_fin;
    logic                        w_flag_mid, w_flag_fin, w_establish;
    logic [TW-1:0]               w_rem, w_el, w_per, w_span, w_age;
    logic                        w_rem_pos, w_rem_sat, w_el_pos, w_el_sat;
    logic                        w_need_dvp, w_need_dvh;
    logic [HW-1:0]               w_prov, w_health;
    logic signed [PW-1:0]        w_dx, w_dz, w_dbx, w_dbz, w_bq;
    logic [PW-1:0]               w_adx, w_adz;
    logic signed [POS_WIDTH-1:0] w_bmeas, w_blend, w_pos_x, w_pos_z;
    logic [tosu_pkg::ID_W-1:0]   w_id;
    t_state                      w_after_bl;
    logic                        w_fire;

    always_comb begin
        w_start   = r_mode == tosu_pkg::MODE_START;
        w_live    = !w_start && r_live;
        w_matched = w_live && (r_mode == tosu_pkg::MODE_MATCH);
        w_update  = w_start || w_live;

        w_promote_mid = w_start ? (r_now + r_period) : r_promote;
        w_last_mid    = (w_start || w_matched) ? r_now : r_last;
        w_flag_mid    = w_start ? 1'b1 : r_flag;
        w_est_mid     = w_start ? '0 : r_est;

        w_rem     = w_promote_mid - r_now;
        w_rem_pos = !w_rem[TW-1] && (w_rem != '0);
        w_per     = (r_period == '0) ? TW'(1) : r_period;
        w_rem_sat = w_rem >= w_per;

        w_el     = r_now - w_last_mid;
        w_el_pos = !w_el[TW-1] && (w_el != '0);
        if (w_flag_mid) begin
            w_span = (r_pdeath == '0) ? TW'(1) : r_pdeath;
        end else begin
            w_span = (r_death == '0) ? TW'(1) : r_death;
        end
        w_el_sat = w_el >= w_span;

        w_need_dvp  = w_update && w_flag_mid && w_rem_pos && !w_rem_sat;
        w_need_dvh  = w_update && !w_start && w_el_pos && !w_el_sat;
        w_establish = w_update && w_flag_mid && !w_rem_pos;
        w_flag_fin  = w_flag_mid && !w_establish;
        w_est_fin   = w_establish ? r_now : w_est_mid;

        if (w_need_dvp) begin
            w_prov = r_prov_q;
        end else if (w_update && w_flag_mid && w_rem_pos) begin
            w_prov = tosu_pkg::ONE_Q16;
        end else begin
            w_prov = '0;
        end

        if (!w_update) begin
            w_health = '0;
        end else if (w_start || !w_el_pos) begin
            w_health = tosu_pkg::ONE_Q16;
        end else if (w_el_sat) begin
            w_health = '0;
        end else begin
            w_health = r_health_q;
        end

        w_age = (w_update && !w_flag_mid) ? (r_now - w_est_mid) : '0;

        if (w_start) begin
            w_pos_x = r_mx;
            w_pos_z = r_mz;
        end else if (w_matched) begin
            w_pos_x = r_new_x;
            w_pos_z = r_new_z;
        end else begin
            w_pos_x = r_px;
            w_pos_z = r_pz;
        end
        w_id = w_start ? r_next_id : r_cur_id;
    end

    always_comb begin
        w_dx    = PW'(r_mx) - PW'(r_px);
        w_dz    = PW'(r_mz) - PW'(r_pz);
        w_adx   = w_dx[PW-1] ? (~w_dx + 1'b1) : w_dx;
        w_adz   = w_dz[PW-1] ? (~w_dz + 1'b1) : w_dz;
        w_dbx   = PW'(r_px) - PW'(r_mx);
        w_dbz   = PW'(r_pz) - PW'(r_mz);
        w_bq    = $signed(w_acc[POS_WIDTH+FW:FW]);
        w_bmeas = (r_state == S_BLX) ? r_mx : r_mz;
        w_blend = POS_WIDTH'(PW'(w_bmeas) + w_bq);
    end

    // operand select for the shared unit
    always_comb begin
        w_cmd.start = r_go && !w_stat.busy && !(r_state inside {S_IDLE, S_DONE});
        w_cmd.op    = tosu_pkg::OP_MUL;
        w_count     = CNT_W'(FW);
        w_init      = '0;
        w_a         = '0;
        w_b         = '0;
        case (r_state)
            S_SQX: begin
                w_count = CNT_W'(PW);
                w_init  = r_flag ? AW'(r_penalty) : '0;
                w_a     = AW'(w_adx);
                w_b     = MPLR_W'(w_adx);
            end
            S_SQZ: begin
                w_count = CNT_W'(PW);
                w_init  = w_acc;
                w_a     = AW'(w_adz);
                w_b     = MPLR_W'(w_adz);
            end
            S_BLX: begin
                w_init = AW'(tosu_pkg::ROUND_Q16);
                w_a    = AW'(w_dbx);
                w_b    = MPLR_W'(r_smooth);
            end
            S_BLZ: begin
                w_init = AW'(tosu_pkg::ROUND_Q16);
                w_a    = AW'(w_dbz);
                w_b    = MPLR_W'(r_smooth);
            end
            S_DVP: begin
                w_cmd.op = tosu_pkg::OP_DIV;
                w_init   = AW'(w_rem);
                w_a      = AW'(w_per);
            end
            S_DVH: begin
                w_cmd.op = tosu_pkg::OP_DIV;
                w_init   = AW'(w_el);
                w_a      = AW'(w_span);
            end
            default: begin
                w_init = '0;
            end
        endcase
    end

    tosu_serial_unit #(
        .MPLR_W (MPLR_W),
        .CNT_W  (CNT_W)
    ) u_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_count    (w_count),
        .i_acc_init (w_init),
        .i_a        (w_a),
        .i_b        (w_b),
        .o_stat     (w_stat),
        .o_acc      (w_acc),
        .o_b        (w_bout)
    );

    assign w_fire = (r_state == S_DONE) && (!o_valid || i_ready);

    always_comb begin
        if (w_need_dvp) begin
            w_after_bl = S_DVP;
        end else if (w_need_dvh) begin
            w_after_bl = S_DVH;
        end else begin
            w_after_bl = S_DONE;
        end

        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_SQX;
            S_SQX:  if (w_stat.done) n_state = S_SQZ;
            S_SQZ:  if (w_stat.done) n_state = w_matched ? S_BLX : w_after_bl;
            S_BLX:  if (w_stat.done) n_state = S_BLZ;
            S_BLZ:  if (w_stat.done) n_state = w_after_bl;
            S_DVP:  if (w_stat.done) n_state = w_need_dvh ? S_DVH : S_DONE;
            S_DVH:  if (w_stat.done) n_state = S_DONE;
            S_DONE: if (w_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            o_valid   <= 1'b0;
            r_smooth  <= 16'd32768;
            r_penalty <= 32'd131072;
            r_period  <= 32'd1000;
            r_death   <= 32'd1000;
            r_pdeath  <= 32'd500;
            r_live    <= 1'b0;
            r_px      <= '0;
            r_pz      <= '0;
            r_last    <= '0;
            r_promote <= '0;
            r_est     <= '0;
            r_flag    <= 1'b1;
            r_next_id <= '0;
            r_cur_id  <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= n_state != r_state;

            if (w_fire) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tosu_pkg::CFG_SMOOTH:  r_smooth  <= i_cfg_data[FW-1:0];
                    tosu_pkg::CFG_PENALTY: r_penalty <= i_cfg_data;
                    tosu_pkg::CFG_PERIOD:  r_period  <= i_cfg_data;
                    tosu_pkg::CFG_DEATH:   r_death   <= i_cfg_data;
                    tosu_pkg::CFG_PDEATH:  r_pdeath  <= i_cfg_data;
                    default: r_smooth <= r_smooth;
                endcase
            end

            if (w_fire && w_update) begin
                r_live    <= 1'b1;
                r_px      <= w_pos_x;
                r_pz      <= w_pos_z;
                r_last    <= w_last_mid;
                r_promote <= w_promote_mid;
                r_est     <= w_est_fin;
                r_flag    <= w_flag_fin;
                if (w_start) begin
                    r_cur_id  <= r_next_id;
                    r_next_id <= r_next_id + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_mode <= i_mode;
            r_mx   <= i_meas_x;
            r_mz   <= i_meas_z;
            r_now  <= i_cur_time;
        end

        if (w_stat.done) begin
            case (r_state)
                S_SQZ: r_cost     <= w_acc;
                S_BLX: r_new_x    <= w_blend;
                S_BLZ: r_new_z    <= w_blend;
                S_DVP: r_prov_q   <= {1'b0, w_bout[FW-1:0]};
                S_DVH: r_health_q <= tosu_pkg::ONE_Q16 - {1'b0, w_bout[FW-1:0]};
                default: r_cost   <= r_cost;
            endcase
        end

        if (w_fire) begin
            o_track_id       <= w_id;
            o_pos_x          <= w_pos_x;
            o_pos_z          <= w_pos_z;
            o_match_cost     <= r_cost;
            o_health         <= w_health;
            o_provisionality <= w_prov;
            o_age            <= w_age;
            o_is_provisional <= w_flag_fin;
            o_is_matched     <= w_matched;
        end
    end

    assign o_ready     = r_state == S_IDLE;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: sv/tosu_checker.sv
// Port-level checker for the tracked object state update block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module tosu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_track_id,
    input wire logic [16:0] o_health,
    input wire logic [16:0] o_provisionality,
    input wire logic [31:0] o_age,
    input wire logic        o_is_provisional
);

    // block is busy right after taking a transaction
    `TOSU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // stalled result holds
    `TOSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_track_id))

    `TOSU_ASSERT_IMPL(a_health_range, i_clk, i_rst_n, o_valid, o_health <= 17'h10000)

    // remaining provisional time only on a provisional track
    `TOSU_ASSERT_IMPL(a_prov_flag, i_clk, i_rst_n, o_valid && (o_provisionality != 17'd0), o_is_provisional)

    // age counts only once established
    `TOSU_ASSERT_IMPL(a_age_flag, i_clk, i_rst_n, o_valid && (o_age != 32'd0), !o_is_provisional)

endmodule

bind tracked_object_state_update tosu_checker u_tosu_checker (.*);

`default_nettype wire

FILE: verif/tracked_object_state_update_test.sv
// Testbench: tracked_object_state_update checked against a track predictor.
`timescale 1ns / 1ps

module tracked_object_state_update_test;
    import tosu_pkg::*;

    localparam int PW = 24;
    localparam logic [1:0] MODE_COAST = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

    typedef struct {
        logic [ID_W-1:0]     track_id;
        logic [PW-1:0]       pos_x;
        logic [PW-1:0]       pos_z;
        logic [ACC_W-1:0]    match_cost;
        logic [HEALTH_W-1:0] health;
        logic [HEALTH_W-1:0] provisionality;
        logic [TIME_W-1:0]   age;
        logic                is_provisional;
        logic                is_matched;
    } track_report_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_mode = '0;
    logic signed [PW-1:0]   i_meas_x = '0;
    logic signed [PW-1:0]   i_meas_z = '0;
    logic [TIME_W-1:0]      i_cur_time = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [ID_W-1:0]        o_track_id;
    logic signed [PW-1:0]   o_pos_x;
    logic signed [PW-1:0]   o_pos_z;
    logic [ACC_W-1:0]       o_match_cost;
    logic [HEALTH_W-1:0]    o_health;
    logic [HEALTH_W-1:0]    o_provisionality;
    logic [TIME_W-1:0]      o_age;
    logic                   o_is_provisional;
    logic                   o_is_matched;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [TIME_W-1:0]      i_cfg_data = '0;

    tracked_object_state_update #(.POS_WIDTH(PW)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_meas_x(i_meas_x), .i_meas_z(i_meas_z), .i_cur_time(i_cur_time),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_track_id(o_track_id), .o_pos_x(o_pos_x), .o_pos_z(o_pos_z),
        .o_match_cost(o_match_cost), .o_health(o_health),
        .o_provisionality(o_provisionality), .o_age(o_age),
        .o_is_provisional(o_is_provisional), .o_is_matched(o_is_matched),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of registers and track state
    logic [FRAC_W-1:0]    cfg_smooth;
    logic [31:0]          cfg_penalty, cfg_period, cfg_death, cfg_pdeath;
    logic                 trk_live, trk_prov, trk_matched;
    logic signed [PW-1:0] trk_x, trk_z;
    logic [TIME_W-1:0]    trk_last_match, trk_promote, trk_established;
    logic [ID_W-1:0]      trk_next_id, trk_id;

    track_report_t expected_reports[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_settings = 1;

    task automatic reset_track_model();
        cfg_smooth = 16'd32768;
        cfg_penalty = 32'd131072;
        cfg_period = 32'd1000;
        cfg_death = 32'd1000;
        cfg_pdeath = 32'd500;
        trk_live = 1'b0;
        trk_prov = 1'b1;
        trk_matched = 1'b0;
        trk_x = '0;
        trk_z = '0;
        trk_last_match = '0;
        trk_promote = '0;
        trk_established = '0;
        trk_next_id = '0;
        trk_id = '0;
    endtask

    function automatic longint signed wrap_diff(input logic [31:0] a, input logic [31:0] b);
        logic signed [31:0] d;
        longint signed v;
        d = a - b;
        v = d;
        return v;
    endfunction

    function automatic logic signed [PW-1:0] blend_pos(input logic signed [PW-1:0] held,
                                                       input logic signed [PW-1:0] meas,
                                                       input logic [FRAC_W-1:0] w);
        longint signed acc, hw, mw, kw;
        hw = held;
        mw = meas;
        kw = w;
        acc = hw * kw + mw * (64'sd65536 - kw) + 64'sd32768;
        acc = acc >>> 16;
        return acc[PW-1:0];
    endfunction

    function automatic logic [HEALTH_W-1:0] health_at(input logic [31:0] now,
                                                      input logic [31:0] span);
        longint signed el;
        longint unsigned loss;
        logic [31:0] sp;
        el = wrap_diff(now, trk_last_match);
        if (el <= 0)
            return ONE_Q16;
        sp = (span == 0) ? 32'd1 : span;
        loss = el;
        loss = (loss << 16) / sp;
        if (loss >= 65536)
            return '0;
        return ONE_Q16 - loss[HEALTH_W-1:0];
    endfunction

    function automatic track_report_t predict_track_step(input logic [1:0] mode,
                                                         input logic signed [PW-1:0] mx,
                                                         input logic signed [PW-1:0] mz,
                                                         input logic [31:0] now);
        track_report_t r;
        longint signed dx, dz, rem;
        longint unsigned cost, frac;
        logic [31:0] per;
        logic upd;
        dx = mx;
        dx = dx - trk_x;
        dz = mz;
        dz = dz - trk_z;
        cost = dx * dx + dz * dz;
        if (trk_prov)
            cost = cost + cfg_penalty;
        upd = 1'b1;
        r.health = '0;
        r.provisionality = '0;
        r.age = '0;
        if (mode == MODE_START) begin
            trk_x = mx;
            trk_z = mz;
            trk_promote = now + cfg_period;
            trk_last_match = now;
            trk_established = '0;
            trk_id = trk_next_id;
            trk_next_id = trk_next_id + 1;
            trk_prov = 1'b1;
            trk_matched = 1'b0;
            trk_live = 1'b1;
        end else if (!trk_live) begin
            upd = 1'b0;
        end else if (mode == MODE_MATCH) begin
            trk_last_match = now;
            trk_matched = 1'b1;
            trk_x = blend_pos(trk_x, mx, cfg_smooth);
            trk_z = blend_pos(trk_z, mz, cfg_smooth);
        end else begin
            trk_matched = 1'b0;
        end
        if (upd) begin
            if (trk_prov) begin
                rem = wrap_diff(trk_promote, now);
                if (rem <= 0) begin
                    trk_prov = 1'b0;
                    trk_established = now;
                end else begin
                    per = (cfg_period == 0) ? 32'd1 : cfg_period;
                    frac = rem;
                    frac = (frac << 16) / per;
                    r.provisionality = (frac > 65536) ? ONE_Q16 : frac[HEALTH_W-1:0];
                end
                r.health = health_at(now, cfg_pdeath);
            end else begin
                r.age = now - trk_established;
                r.health = health_at(now, cfg_death);
            end
            if (mode == MODE_START)
                r.health = ONE_Q16;
        end
        r.track_id = trk_id;
        r.pos_x = trk_x;
        r.pos_z = trk_z;
        r.match_cost = cost[ACC_W-1:0];
        r.is_provisional = trk_prov;
        r.is_matched = upd && trk_matched;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 50)
            $display("ERR t=%0t result %0d: %s", $realtime, n_checked, msg);
    endtask

    task automatic check_report();
        track_report_t want;
        if (expected_reports.size() == 0) begin
            report_mismatch("result with no transaction pending");
        end else begin
            want = expected_reports.pop_front();
            if (o_track_id !== want.track_id)
                report_mismatch($sformatf("track_id want %0h got %0h", want.track_id, o_track_id));
            if (o_pos_x !== want.pos_x)
                report_mismatch($sformatf("pos_x want %0h got %0h", want.pos_x, o_pos_x));
            if (o_pos_z !== want.pos_z)
                report_mismatch($sformatf("pos_z want %0h got %0h", want.pos_z, o_pos_z));
            if (o_match_cost !== want.match_cost)
                report_mismatch($sformatf("match_cost want %0h got %0h",
                                          want.match_cost, o_match_cost));
            if (o_health !== want.health)
                report_mismatch($sformatf("health want %0h got %0h", want.health, o_health));
            if (o_provisionality !== want.provisionality)
                report_mismatch($sformatf("provisionality want %0h got %0h",
                                          want.provisionality, o_provisionality));
            if (o_age !== want.age)
                report_mismatch($sformatf("age want %0h got %0h", want.age, o_age));
            if (o_is_provisional !== want.is_provisional)
                report_mismatch($sformatf("is_provisional want %0b got %0b",
                                          want.is_provisional, o_is_provisional));
            if (o_is_matched !== want.is_matched)
                report_mismatch($sformatf("is_matched want %0b got %0b",
                                          want.is_matched, o_is_matched));
        end
        n_checked++;
    endtask

    // result side: check on transaction, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_report();
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input logic [1:0] mode, input logic signed [PW-1:0] mx,
                             input logic signed [PW-1:0] mz, input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_meas_x <= mx;
        i_meas_z <= mz;
        i_cur_time <= now;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        expected_reports.push_back(predict_track_step(mode, mx, mz, now));
        n_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_SMOOTH:  cfg_smooth = val[FRAC_W-1:0];
            CFG_PENALTY: cfg_penalty = val;
            CFG_PERIOD:  cfg_period = val;
            CFG_DEATH:   cfg_death = val;
            CFG_PDEATH:  cfg_pdeath = val;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [31:0] smooth, input logic [31:0] penalty,
                                input logic [31:0] period, input logic [31:0] death,
                                input logic [31:0] pdeath);
        write_reg(CFG_SMOOTH, smooth);
        write_reg(CFG_PENALTY, penalty);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_DEATH, death);
        write_reg(CFG_PDEATH, pdeath);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // updates before any start leave the state alone
    task automatic test_no_track();
        send_item(MODE_MATCH, POS_MAX, POS_MIN, 32'd0);
        send_item(MODE_COAST, POS_MIN, POS_MAX, 32'hFFFF_FFFF);
        send_item(MODE_SPARE, 24'h5A5A5A, 24'hA5A5A5, 32'h1234_5678);
    endtask

    // full life of a track under reset register values
    task automatic test_track_lifecycle();
        send_item(MODE_START, POS_MAX, POS_MIN, 32'd100);
        send_item(MODE_MATCH, POS_MIN, POS_MAX, 32'd300);
        send_item(MODE_COAST, 24'd0, 24'd0, 32'd600);
        send_item(MODE_SPARE, 24'd256, -24'sd256, 32'd700);
        send_item(MODE_COAST, 24'd0, 24'd0, 32'd1100);
        send_item(MODE_MATCH, 24'd1000, 24'd2000, 32'd1500);
        send_item(MODE_COAST, 24'd0, 24'd0, 32'd1400);
        send_item(MODE_COAST, 24'd0, 24'd0, 32'd3000);
        send_item(MODE_START, 24'd77, -24'sd77, 32'hFFFF_FF00);
        send_item(MODE_COAST, 24'd0, 24'd0, 32'h0000_0100);
        send_item(MODE_START, 24'd1, 24'd1, 32'd5000);
        send_item(MODE_COAST, 24'd1, 24'd1, 32'd4000);
        wait_idle();
    endtask

    // zero, maximum and other edge register values
    task automatic test_config_extremes();
        write_config(32'hFFFF_0000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_item(MODE_START, 24'd0, 24'd0, 32'd10);
        send_item(MODE_MATCH, POS_MAX, POS_MAX, 32'd10);
        send_item(MODE_COAST, 24'd0, 24'd0, 32'd11);
        wait_idle();
        write_config(32'h0000_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_START, POS_MIN, POS_MIN, 32'd0);
        send_item(MODE_MATCH, POS_MAX, POS_MAX, 32'h7FFF_FFFF);
        send_item(MODE_COAST, 24'd0, 24'd0, 32'h8000_0000);
        wait_idle();
        write_config(32'd1, 32'd65536, 32'h7FFF_FFFF, 32'd1, 32'd1);
        send_item(MODE_START, 24'd3, 24'd3, 32'd0);
        send_item(MODE_COAST, 24'd0, 24'd0, 32'd1);
        wait_idle();
    endtask

    // tracks with random content, mixed with stray transactions
    task automatic test_random_tracks(input int n_items, input int idle, input int stall);
        int done;
        int len;
        int r;
        logic [31:0] now;
        logic [1:0] mode;
        logic signed [PW-1:0] ax, az, jx, jz;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_config($urandom, $urandom, $urandom_range(3000, 1), $urandom_range(3000, 1),
                     $urandom_range(3000, 1));
        done = 0;
        now = $urandom;
        while (done < n_items) begin
            if ($urandom_range(99) < 12) begin
                send_item($urandom_range(3), $urandom, $urandom, $urandom);
                done++;
            end else begin
                if ($urandom_range(1) == 0)
                    now = $urandom;
                ax = $urandom;
                az = $urandom;
                send_item(MODE_START, ax, az, now);
                done++;
                len = $urandom_range(30, 1);
                repeat (len) begin
                    now = now + $urandom_range(600);
                    if ($urandom_range(99) < 4)
                        now = now - $urandom_range(300, 1);
                    r = $urandom_range(99);
                    mode = (r < 60) ? MODE_MATCH : (r < 95) ? MODE_COAST : MODE_SPARE;
                    jx = $urandom_range(8191) - 4096;
                    jz = $urandom_range(8191) - 4096;
                    send_item(mode, ax + jx, az + jz, now);
                    done++;
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        reset_track_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_no_track();
        test_track_lifecycle();
        test_config_extremes();
        test_random_tracks(410, 0, 0);
        test_random_tracks(410, 57, 0);
        test_random_tracks(410, 0, 57);
        test_random_tracks(410, 27, 27);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d transactions over %0d register settings, checked %0d results.",
                 n_sent, n_settings, n_checked);
        $display("Covered start, matched, unmatched and spare modes under four idling mixes.");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("timeout with %0d results pending", expected_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
